[design/scfq_pkg.sv]
`default_nettype none

package scfq_pkg;

  localparam int MARGIN_W = 6;
  localparam logic [MARGIN_W-1:0] BUSY_MARGIN_RESET = 6'd10;

  localparam logic CMD_SPI = 1'b0;
  localparam logic CMD_POP = 1'b1;

  localparam logic KIND_SPI = 1'b0;
  localparam logic KIND_POP = 1'b1;

  localparam logic [2:0] CODE_NOP     = 3'd0;
  localparam logic [2:0] CODE_STATUS  = 3'd1;
  localparam logic [2:0] CODE_SPECIAL = 3'd7;
  localparam logic [2:0] CODE_INIT    = 3'd7;

  localparam logic [7:0] BYTE_INIT    = 8'hFE;
  localparam logic [7:0] BYTE_RELEASE = 8'hFF;

  localparam logic [4:0] STATUS_BUTTONS = 5'd0;
  localparam logic [4:0] STATUS_ENCODER = 5'd1;
  localparam logic [4:0] STATUS_FILL    = 5'd2;

  typedef struct packed {
    logic       cmd;
    logic [7:0] spi_byte;
    logic [7:0] button_state;
    logic [7:0] encoder_low;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] reply_byte;
    logic       reply_valid;
    logic       encoder_clear;
    logic       busy_res;
    logic       dropped;
    logic       frame_valid;
    logic [2:0] frame_code;
    logic [4:0] frame_length;
    logic [7:0] frame_byte;
    logic       last;
  } out_item_t;

endpackage

`default_nettype wire

[design/scfq_stream_if.sv]
`default_nettype none

interface scfq_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[design/spi_command_frame_queue.sv]
`default_nettype none

// SPI command frame queue. Each input transfer is either one byte received from the SPI
// master or a pop request from the consumer; items are handled one at a time. An SPI byte
// goes through a capture step and an execute step, the latter waiting while the output
// register is full, and yields one result through that register. A pop fetches the frame
// header and then streams one data byte per cycle while the consumer keeps ready high; the
// single read port of the frame byte memory sets that pace. Frames are written straight
// into a ring of QUEUE_DEPTH + 1 slots held in two synchronous memories (headers and data
// bytes); the spare slot is the one being assembled. Memory contents need no clearing
// after reset. busy_margin is written over cfg_if and may only change while the block is
// idle.
module spi_command_frame_queue #(
  parameter int QUEUE_DEPTH = 32,
  parameter int FRAME_BYTES = 31
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  scfq_stream_if.sink        in_if,
  scfq_stream_if.source      out_if,
  scfq_stream_if.sink        cfg_if
);
  import scfq_pkg::*;

  localparam int SLOTS = QUEUE_DEPTH + 1;
  localparam int IW    = $clog2(SLOTS);
  localparam int AW    = $clog2(SLOTS * FRAME_BYTES);
  localparam int FW    = $clog2(QUEUE_DEPTH + 1);
  localparam int SW    = ((FW > MARGIN_W) ? FW : MARGIN_W) + 1;
  localparam int FXW   = (FW > 8) ? FW : 9;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_DATA = 3'b100
  } state_e;

  state_e state_q, state_d;
  in_item_t item_q, item_d;
  out_item_t out_q, out_d;
  logic out_vld_q, out_vld_d;
  logic [MARGIN_W-1:0] margin_q;
  logic [5:0] rx_q, rx_d;
  logic [4:0] rem_q, rem_d;
  logic [2:0] acode_q, acode_d;
  logic [4:0] alen_q, alen_d;
  logic [IW-1:0] head_q, head_d, tail_q, tail_d;
  logic [AW-1:0] head_base_q, head_base_d, tail_base_q, tail_base_d;
  logic [FW-1:0] fill_q, fill_d;
  logic busy_q, busy_d;
  logic [AW-1:0] pop_base_q, pop_base_d;
  logic [2:0] pop_code_q, pop_code_d;
  logic [4:0] pop_len_q, pop_len_d;
  logic [4:0] pop_k_q, pop_k_d;

  logic [7:0] hdr_mem [SLOTS];
  logic [7:0] byte_mem [SLOTS*FRAME_BYTES];
  logic [7:0] hdr_rd_q, byte_rd_q;

  logic hdr_we, byte_we, byte_re;
  logic [IW-1:0] hdr_wa;
  logic [7:0] hdr_wd;
  logic [AW-1:0] byte_wa, byte_ra;

  logic out_free;
  assign out_free = !out_vld_q || out_if.ready;

  assign in_if.ready    = (state_q == ST_IDLE);
  assign cfg_if.ready   = 1'b1;
  assign out_if.valid   = out_vld_q;
  assign out_if.payload = out_q;

  always_comb begin
    logic [2:0] code;
    logic [4:0] n;
    logic [5:0] idx;
    logic [FXW-1:0] fill_x;
    logic [SW-1:0] sum;
    logic cplt;
    logic emit;
    logic [2:0] hcode;
    logic [4:0] hlen;
    out_item_t res;

    state_d     = state_q;
    item_d      = item_q;
    out_d       = out_q;
    out_vld_d   = out_vld_q && !out_if.ready;
    rx_d        = rx_q;
    rem_d       = rem_q;
    acode_d     = acode_q;
    alen_d      = alen_q;
    head_d      = head_q;
    head_base_d = head_base_q;
    tail_d      = tail_q;
    tail_base_d = tail_base_q;
    fill_d      = fill_q;
    busy_d      = busy_q;
    pop_base_d  = pop_base_q;
    pop_code_d  = pop_code_q;
    pop_len_d   = pop_len_q;
    pop_k_d     = pop_k_q;
    hdr_we      = 1'b0;
    hdr_wa      = tail_q;
    hdr_wd      = '0;
    byte_we     = 1'b0;
    byte_wa     = tail_base_q;
    byte_re     = 1'b0;
    byte_ra     = head_base_q;
    code        = item_q.spi_byte[7:5];
    n           = item_q.spi_byte[4:0];
    idx         = rx_q - 6'd1;
    fill_x      = FXW'(fill_q);
    sum         = '0;
    cplt        = 1'b0;
    emit        = 1'b0;
    hcode       = hdr_rd_q[7:5];
    hlen        = hdr_rd_q[4:0];
    res         = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_if.valid) begin
          item_d  = in_if.payload;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          state_d = ST_IDLE;
          if (item_q.cmd == CMD_SPI) begin
            emit     = 1'b1;
            res.kind = KIND_SPI;
            if (rx_q == '0) begin
              case (code)
                CODE_NOP: ;
                CODE_STATUS: begin
                  case (n)
                    STATUS_BUTTONS: begin
                      res.reply_byte  = item_q.button_state;
                      res.reply_valid = 1'b1;
                    end
                    STATUS_ENCODER: begin
                      res.reply_byte    = item_q.encoder_low;
                      res.reply_valid   = 1'b1;
                      res.encoder_clear = 1'b1;
                    end
                    STATUS_FILL: begin
                      res.reply_byte  = (fill_x > FXW'(255)) ? 8'hFF : fill_x[7:0];
                      res.reply_valid = 1'b1;
                    end
                    default: ;
                  endcase
                end
                CODE_SPECIAL: begin
                  if (item_q.spi_byte == BYTE_INIT) begin
                    head_d      = '0;
                    head_base_d = '0;
                    tail_d      = '0;
                    tail_base_d = '0;
                    fill_d      = '0;
                    acode_d     = CODE_INIT;
                    alen_d      = '0;
                    rem_d       = '0;
                    cplt        = 1'b1;
                  end else if (item_q.spi_byte == BYTE_RELEASE) begin
                    if (fill_q == '0) busy_d = 1'b0;
                  end
                end
                default: begin
                  acode_d = code;
                  alen_d  = (n > 5'(FRAME_BYTES)) ? 5'(FRAME_BYTES) : n;
                  rem_d   = n;
                  rx_d    = 6'd1;
                  if (n == '0) cplt = 1'b1;
                end
              endcase
            end else begin
              if (rem_q != '0) begin
                if (idx < 6'(FRAME_BYTES)) begin
                  byte_we = 1'b1;
                  byte_wa = tail_base_q + AW'(idx);
                end
                rx_d  = rx_q + 6'd1;
                rem_d = rem_q - 5'd1;
              end
              if (rem_d == '0) cplt = 1'b1;
            end
            if (cplt) begin
              rx_d = '0;
              if (fill_d >= FW'(QUEUE_DEPTH)) begin
                res.dropped = 1'b1;
              end else begin
                hdr_we = 1'b1;
                hdr_wa = tail_d;
                hdr_wd = {acode_d, alen_d};
                if (tail_d == IW'(SLOTS - 1)) begin
                  tail_d      = '0;
                  tail_base_d = '0;
                end else begin
                  tail_d      = tail_d + IW'(1);
                  tail_base_d = tail_base_d + AW'(FRAME_BYTES);
                end
                fill_d = fill_d + FW'(1);
                sum    = SW'(fill_d) + SW'(margin_q);
                if (sum >= SW'(QUEUE_DEPTH)) busy_d = 1'b1;
              end
            end
            res.busy_res = busy_d;
          end else begin
            res.kind = KIND_POP;
            res.last = 1'b1;
            if (fill_q == '0) begin
              emit = 1'b1;
            end else begin
              fill_d = fill_q - FW'(1);
              if (head_q == IW'(SLOTS - 1)) begin
                head_d      = '0;
                head_base_d = '0;
              end else begin
                head_d      = head_q + IW'(1);
                head_base_d = head_base_q + AW'(FRAME_BYTES);
              end
              res.frame_valid  = 1'b1;
              res.frame_code   = hcode;
              res.frame_length = hlen;
              if (hcode == CODE_INIT) begin
                emit              = 1'b1;
                rx_d              = '0;
                rem_d             = '0;
                head_d            = '0;
                head_base_d       = '0;
                tail_d            = '0;
                tail_base_d       = '0;
                fill_d            = '0;
                busy_d            = 1'b0;
                res.encoder_clear = 1'b1;
              end else if (hlen == '0) begin
                emit = 1'b1;
              end else begin
                pop_base_d = head_base_q;
                pop_code_d = hcode;
                pop_len_d  = hlen;
                pop_k_d    = '0;
                byte_re    = 1'b1;
                byte_ra    = head_base_q;
                state_d    = ST_DATA;
              end
            end
            res.busy_res = busy_d;
          end
        end
      end
      ST_DATA: begin
        if (out_free) begin
          emit             = 1'b1;
          res.kind         = KIND_POP;
          res.busy_res     = busy_q;
          res.frame_valid  = 1'b1;
          res.frame_code   = pop_code_q;
          res.frame_length = pop_len_q;
          res.frame_byte   = byte_rd_q;
          res.last         = ((pop_k_q + 5'd1) == pop_len_q);
          if (res.last) begin
            state_d = ST_IDLE;
          end else begin
            pop_k_d = pop_k_q + 5'd1;
            byte_re = 1'b1;
            byte_ra = pop_base_q + AW'(pop_k_d);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (emit) begin
      out_d     = res;
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_vld_q   <= 1'b0;
      margin_q    <= BUSY_MARGIN_RESET;
      rx_q        <= '0;
      rem_q       <= '0;
      acode_q     <= '0;
      alen_q      <= '0;
      head_q      <= '0;
      head_base_q <= '0;
      tail_q      <= '0;
      tail_base_q <= '0;
      fill_q      <= '0;
      busy_q      <= 1'b0;
      pop_k_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_vld_q   <= out_vld_d;
      if (cfg_if.valid) margin_q <= cfg_if.payload;
      rx_q        <= rx_d;
      rem_q       <= rem_d;
      acode_q     <= acode_d;
      alen_q      <= alen_d;
      head_q      <= head_d;
      head_base_q <= head_base_d;
      tail_q      <= tail_d;
      tail_base_q <= tail_base_d;
      fill_q      <= fill_d;
      busy_q      <= busy_d;
      pop_k_q     <= pop_k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    out_q      <= out_d;
    pop_base_q <= pop_base_d;
    pop_code_q <= pop_code_d;
    pop_len_q  <= pop_len_d;
  end

  always_ff @(posedge clk_i) begin
    if (hdr_we) hdr_mem[hdr_wa] <= hdr_wd;
    if (state_q == ST_IDLE) hdr_rd_q <= hdr_mem[head_q];
  end

  always_ff @(posedge clk_i) begin
    if (byte_we) byte_mem[byte_wa] <= item_q.spi_byte;
    if (byte_re) byte_rd_q <= byte_mem[byte_ra];
  end

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
module tb_top;
  import scfq_pkg::*;

  localparam int QUEUE_DEPTH = 32;
  localparam int FRAME_BYTES = 31;
  localparam int CYCLE_LIMIT = 2_000_000;

  typedef logic [MARGIN_W-1:0] margin_t;

  class frame_queue_checker;
    margin_t     margin;
    logic [5:0]  rx_pos;
    logic [4:0]  remaining;
    logic [2:0]  asm_code;
    logic [4:0]  asm_len;
    logic [7:0]  asm_bytes [FRAME_BYTES];
    logic [7:0]  slot_hdr [QUEUE_DEPTH];
    logic [7:0]  slot_bytes [QUEUE_DEPTH][FRAME_BYTES];
    int unsigned head;
    int unsigned tail;
    int unsigned fill;
    logic        busy;
    out_item_t   awaited_results[$];
    int          errors;

    function new();
      margin    = BUSY_MARGIN_RESET;
      rx_pos    = '0;
      remaining = '0;
      asm_code  = '0;
      asm_len   = '0;
      head      = 0;
      tail      = 0;
      fill      = 0;
      busy      = 1'b0;
      errors    = 0;
    endfunction

    function void load_margin(margin_t m);
      margin = m;
    endfunction

    function void clear_queue();
      head = 0;
      tail = 0;
      fill = 0;
    endfunction

    // returns 1 when the queue was full and the frame is lost
    function bit push_frame();
      int unsigned slot;
      if (fill >= QUEUE_DEPTH) return 1'b1;
      slot = tail;
      slot_hdr[slot] = {asm_code, asm_len};
      for (int i = 0; i < asm_len; i++) slot_bytes[slot][i] = asm_bytes[i];
      tail = (slot + 1) % QUEUE_DEPTH;
      fill++;
      if (fill + margin >= QUEUE_DEPTH) busy = 1'b1;
      return 1'b0;
    endfunction

    function void note_transfer(in_item_t it);
      out_item_t   r;
      logic [2:0]  code;
      logic [4:0]  cnt;
      logic [7:0]  hdr;
      bit          complete;
      int unsigned slot;
      r = '0;
      if (it.cmd == CMD_SPI) begin
        r.kind = KIND_SPI;
        complete = 1'b0;
        if (rx_pos == 0) begin
          code = it.spi_byte[7:5];
          cnt  = it.spi_byte[4:0];
          if (code == CODE_STATUS) begin
            if (cnt == STATUS_BUTTONS) begin
              r.reply_byte  = it.button_state;
              r.reply_valid = 1'b1;
            end else if (cnt == STATUS_ENCODER) begin
              r.reply_byte    = it.encoder_low;
              r.reply_valid   = 1'b1;
              r.encoder_clear = 1'b1;
            end else if (cnt == STATUS_FILL) begin
              r.reply_byte  = (fill > 255) ? 8'hFF : 8'(fill);
              r.reply_valid = 1'b1;
            end
          end else if (code == CODE_SPECIAL) begin
            if (it.spi_byte == BYTE_INIT) begin
              clear_queue();
              asm_code  = CODE_INIT;
              asm_len   = '0;
              remaining = '0;
              complete  = 1'b1;
            end else if (it.spi_byte == BYTE_RELEASE) begin
              if (fill == 0) busy = 1'b0;
            end
          end else if (code != CODE_NOP) begin
            asm_code  = code;
            asm_len   = (cnt > FRAME_BYTES) ? 5'(FRAME_BYTES) : cnt;
            remaining = cnt;
            rx_pos    = 6'd1;
            if (cnt == 0) complete = 1'b1;
          end
        end else begin
          if (remaining > 0) begin
            if (rx_pos - 6'd1 < FRAME_BYTES) asm_bytes[rx_pos - 6'd1] = it.spi_byte;
            rx_pos    = rx_pos + 6'd1;
            remaining = remaining - 5'd1;
          end
          if (remaining == 0) complete = 1'b1;
        end
        if (complete) begin
          r.dropped = push_frame();
          rx_pos    = '0;
        end
        r.busy_res = busy;
        awaited_results.push_back(r);
        return;
      end

      r.kind = KIND_POP;
      if (fill == 0) begin
        r.last     = 1'b1;
        r.busy_res = busy;
        awaited_results.push_back(r);
        return;
      end
      slot = head;
      hdr  = slot_hdr[slot];
      head = (slot + 1) % QUEUE_DEPTH;
      fill--;
      r.frame_valid  = 1'b1;
      r.frame_code   = hdr[7:5];
      r.frame_length = hdr[4:0];
      if (hdr[7:5] == CODE_INIT) begin
        rx_pos    = '0;
        remaining = '0;
        clear_queue();
        busy = 1'b0;
        r.encoder_clear = 1'b1;
        r.last          = 1'b1;
        r.busy_res      = busy;
        awaited_results.push_back(r);
      end else if (hdr[4:0] == 0) begin
        r.last     = 1'b1;
        r.busy_res = busy;
        awaited_results.push_back(r);
      end else begin
        for (int k = 0; k < hdr[4:0]; k++) begin
          r.frame_byte = slot_bytes[slot][k];
          r.last       = (k + 1 == hdr[4:0]);
          r.busy_res   = busy;
          awaited_results.push_back(r);
        end
      end
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] seen);
      if (seen !== want) begin
        $error("%s: expected %0h, got %0h", name, want, seen);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (awaited_results.size() == 0) begin
        $error("result with nothing awaited: %0h", got);
        errors++;
        return;
      end
      want = awaited_results.pop_front();
      check_field("kind", want.kind, got.kind);
      check_field("reply_byte", want.reply_byte, got.reply_byte);
      check_field("reply_valid", want.reply_valid, got.reply_valid);
      check_field("encoder_clear", want.encoder_clear, got.encoder_clear);
      check_field("busy_res", want.busy_res, got.busy_res);
      check_field("dropped", want.dropped, got.dropped);
      check_field("frame_valid", want.frame_valid, got.frame_valid);
      check_field("frame_code", want.frame_code, got.frame_code);
      check_field("frame_length", want.frame_length, got.frame_length);
      check_field("frame_byte", want.frame_byte, got.frame_byte);
      check_field("last", want.last, got.last);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  always #5 clk_i = ~clk_i;

  scfq_stream_if #(.payload_t(in_item_t))  in_ch ();
  scfq_stream_if #(.payload_t(out_item_t)) out_ch ();
  scfq_stream_if #(.payload_t(margin_t))   cfg_ch ();

  spi_command_frame_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .FRAME_BYTES(FRAME_BYTES)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (in_ch),
    .out_if(out_ch),
    .cfg_if(cfg_ch)
  );

  frame_queue_checker sb = new();
  bit steady;
  int items_sent;
  int stall_left;
  int cycles;

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return 0;
    if (r < 85) return $urandom_range(1, 4);
    if (r < 95) return $urandom_range(5, 30);
    return FRAME_BYTES;
  endfunction

  always @(negedge clk_i) begin
    if (steady) begin
      out_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(0, 99) < 20)
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) sb.check_result(out_ch.payload);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_item(logic cmd, logic [7:0] b, logic [7:0] btn, logic [7:0] enc);
    in_item_t it;
    int       gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    it.cmd          = cmd;
    it.spi_byte     = b;
    it.button_state = btn;
    it.encoder_low  = enc;
    in_ch.payload <= it;
    in_ch.valid   <= 1'b1;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sb.note_transfer(it);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_random(logic cmd, logic [7:0] b);
    send_item(cmd, b, 8'($urandom), 8'($urandom));
  endtask

  task automatic send_frame(logic [2:0] code, int n);
    send_random(CMD_SPI, {code, 5'(n)});
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 4) send_random(CMD_POP, 8'($urandom));
      send_random(CMD_SPI, 8'($urandom));
    end
  endtask

  task automatic write_margin(margin_t m);
    in_ch.valid <= 1'b0;
    while (sb.awaited_results.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    cfg_ch.payload <= m;
    cfg_ch.valid   <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    sb.load_margin(m);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  // fill_mode pushes mostly empty frames and rarely pops, to reach busy and full
  task automatic random_phase(int budget, bit fill_mode);
    int         stop;
    int         r;
    logic [2:0] code;
    logic [4:0] sel;
    stop = items_sent + budget;
    while (items_sent < stop) begin
      r    = $urandom_range(0, 99);
      code = 3'($urandom_range(2, 6));
      sel  = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 2));
      if (fill_mode) begin
        if (r < 94) send_frame(code, ($urandom_range(0, 7) == 0) ? 1 : 0);
        else if (r < 97) send_random(CMD_SPI, {CODE_STATUS, STATUS_FILL});
        else send_random(CMD_POP, 8'($urandom));
      end else begin
        if (r < 10) send_random(CMD_SPI, {CODE_STATUS, sel});
        else if (r < 55) send_frame(code, pick_len());
        else if (r < 75) send_random(CMD_POP, 8'($urandom));
        else if (r < 79) send_random(CMD_SPI, BYTE_INIT);
        else if (r < 85) send_random(CMD_SPI, BYTE_RELEASE);
        else if (r < 90) send_random(CMD_SPI, {CODE_NOP, 5'($urandom)});
        else if (r < 94) send_random(CMD_SPI, 8'($urandom_range(8'hE0, 8'hFD)));
        else send_random(CMD_SPI, 8'($urandom));
      end
    end
  endtask

  initial begin
    int waited;
    rst_ni         = 1'b0;
    steady         = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.payload  = '0;
    out_ch.ready   = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.payload = '0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // status reads, ignored codes, short frames, pops, init
    send_item(CMD_SPI, {CODE_STATUS, STATUS_BUTTONS}, 8'hFF, 8'h00);
    send_item(CMD_SPI, {CODE_STATUS, STATUS_BUTTONS}, 8'h00, 8'hFF);
    send_item(CMD_SPI, {CODE_STATUS, STATUS_ENCODER}, 8'h00, 8'hFF);
    send_item(CMD_SPI, {CODE_STATUS, STATUS_ENCODER}, 8'hFF, 8'h00);
    send_random(CMD_SPI, {CODE_STATUS, 5'd3});
    send_random(CMD_SPI, {CODE_STATUS, 5'd31});
    send_random(CMD_SPI, 8'h00);
    send_random(CMD_SPI, {CODE_NOP, 5'd31});
    send_random(CMD_SPI, {3'd2, 5'd0});
    send_random(CMD_SPI, {3'd6, 5'd3});
    send_random(CMD_SPI, 8'h00);
    send_random(CMD_SPI, 8'hFF);
    send_random(CMD_SPI, 8'hA5);
    send_random(CMD_SPI, {CODE_STATUS, STATUS_FILL});
    send_random(CMD_SPI, 8'hE5);
    send_random(CMD_SPI, BYTE_RELEASE);
    send_random(CMD_POP, 8'h00);
    send_random(CMD_POP, 8'hFF);
    send_random(CMD_POP, 8'h00);
    send_random(CMD_SPI, BYTE_INIT);
    send_random(CMD_POP, 8'h00);
    send_random(CMD_POP, 8'h00);
    send_random(CMD_SPI, BYTE_RELEASE);

    write_margin(margin_t'(QUEUE_DEPTH));
    steady = 1'b1;
    send_frame(3'd3, FRAME_BYTES);
    send_random(CMD_POP, 8'h00);
    steady = 1'b0;
    write_margin(margin_t'(0));
    random_phase(40, 1'b1);
    write_margin(margin_t'(QUEUE_DEPTH - 1));
    random_phase(8, 1'b0);
    write_margin(margin_t'($urandom_range(1, 30)));
    random_phase(8, 1'b0);

    in_ch.valid <= 1'b0;
    waited = 0;
    while (sb.awaited_results.size() != 0 && waited < 20000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (20) @(negedge clk_i);
    if (sb.awaited_results.size() != 0) begin
      $error("%0d results never arrived", sb.awaited_results.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[files.f]
design/scfq_pkg.sv
design/scfq_stream_if.sv
design/spi_command_frame_queue.sv
tb/sv/tb_top.sv
